FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define FRM_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define FRM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/frm_pkg.sv
// shared widths, register map and divider request and response types of the frame rate meter
`default_nettype none

package frm_pkg;

    localparam int TICK_W   = 32;
    localparam int RATE_W   = 32;
    localparam int SMOOTH_W = 36;
    localparam int WTIME_W  = 33;
    localparam int FRAMES_W = 32;
    localparam int PROD_W   = 64;
    localparam int DATA_W   = 32;

    // apb map: one word per register, one spare index decoded as empty
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_TICK_RATE = '0;

    localparam logic [DATA_W-1:0] TICK_RATE_RESET = 32'd100000000;

    typedef struct packed {
        logic                 start;
        logic [PROD_W-1:0]    dividend;
        logic [WTIME_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [RATE_W-1:0]    quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: hdl/frm_if.sv
// valid/ready channel interfaces for duration items and result items
`default_nettype none

interface frm_in_if;
    logic                        valid;
    logic                        ready;
    logic [frm_pkg::TICK_W-1:0]  elapsed_ticks;

    modport source (output valid, output elapsed_ticks, input ready);
    modport sink   (input valid, input elapsed_ticks, output ready);
endinterface

interface frm_out_if;
    logic                          valid;
    logic                          ready;
    logic [frm_pkg::TICK_W-1:0]    frame_dt;
    logic [frm_pkg::RATE_W-1:0]    frame_rate;
    logic [frm_pkg::RATE_W-1:0]    average_rate;
    logic [frm_pkg::SMOOTH_W-1:0]  smoothed_dt;

    modport source (output valid, output frame_dt, output frame_rate,
                    output average_rate, output smoothed_dt, input ready);
    modport sink   (input valid, input frame_dt, input frame_rate,
                    input average_rate, input smoothed_dt, output ready);
endinterface

`default_nettype wire

FILE: hdl/frame_rate_meter_top.sv
// frame rate meter: instant, windowed and smoothed frame statistics from frame durations
//
//  channel   dir  handshake           payload
//  i_in      in   valid/ready         elapsed_ticks[31:0]
//  o_out     out  valid/ready         frame_dt, frame_rate, average_rate, smoothed_dt
//  apb       in   psel/penable/pready tick_rate at byte address 0
//
// one item at a time; the window average is divided only when the window
// closes; each division runs 32 steps through the single shared bit-serial divider
// a zero duration skips the instant-rate division, a saturating quotient ends it early
// synchronous active-low reset clears the window sums, the averages and the handshake
// the output register holds a finished result, so i_in.ready rises again while o_out stalls
// a second result waits in the final state until the output register is free
`default_nettype none

module frame_rate_meter_top #(
    parameter int TICK_BITS      = 32,
    parameter int RATE_FRAC_BITS = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    frm_in_if.sink                            i_in,
    frm_out_if.source                         o_out,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [frm_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [frm_pkg::DATA_W-1:0]   pwdata,
    output logic      [frm_pkg::DATA_W-1:0]   prdata,
    output logic                              pready
);

    // sequencer, one-hot
    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_RATE      = 7'b0000010,
        S_RATE_WAIT = 7'b0000100,
        S_CHECK     = 7'b0001000,
        S_AVG       = 7'b0010000,
        S_AVG_WAIT  = 7'b0100000,
        S_DONE      = 7'b1000000
    } t_state;

    t_state                              r_state;
    t_state                              n_state;

    logic [frm_pkg::DATA_W-1:0]          w_tick_rate;
    logic [frm_pkg::TICK_W-1:0]          w_ticks;
    logic                                w_accept;
    logic                                w_out_free;
    logic                                w_close;
    logic [frm_pkg::WTIME_W-1:0]         w_tick_rate_ext;
    logic [frm_pkg::PROD_W-1:0]          w_prod;
    frm_pkg::t_div_req                   w_div_req;
    frm_pkg::t_div_rsp                   w_div_rsp;

    logic [frm_pkg::TICK_W-1:0]          r_ticks;
    logic [frm_pkg::RATE_W-1:0]          r_rate;
    logic [frm_pkg::PROD_W-1:0]          r_prod;
    logic [frm_pkg::WTIME_W-1:0]         r_wtime;
    logic [frm_pkg::FRAMES_W-1:0]        r_wframes;
    logic [frm_pkg::RATE_W-1:0]          r_avg;
    logic [frm_pkg::SMOOTH_W-1:0]        r_smooth;
    logic [frm_pkg::SMOOTH_W-1:0]        n_smooth;

    logic                                r_out_valid;
    logic [frm_pkg::TICK_W-1:0]          r_out_dt;
    logic [frm_pkg::RATE_W-1:0]          r_out_rate;
    logic [frm_pkg::RATE_W-1:0]          r_out_avg;
    logic [frm_pkg::SMOOTH_W-1:0]        r_out_smooth;

    frm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_tick_rate (w_tick_rate)
    );

    frm_div #(
        .FRAC_BITS (RATE_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // only the low TICK_BITS bits of a duration count
    always_comb begin
        for (int i = 0; i < frm_pkg::TICK_W; i++) begin
            w_ticks[i] = (i < TICK_BITS) ? i_in.elapsed_ticks[i] : 1'b0;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || o_out.ready;

    // window closes once summed ticks pass one second
    assign w_tick_rate_ext = {1'b0, w_tick_rate};
    assign w_close         = r_wtime > w_tick_rate_ext;
    assign w_prod          = frm_pkg::PROD_W'(r_wframes) * frm_pkg::PROD_W'(w_tick_rate);

    // halving moving average in q.4
    assign n_smooth = frm_pkg::SMOOTH_W'(({1'b0, r_smooth} + {1'b0, w_ticks, 4'b0000}) >> 1);

    // divider requests: instant rate first, then the window average
    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = frm_pkg::PROD_W'(w_tick_rate);
        w_div_req.divisor  = {1'b0, r_ticks};
        if (r_state == S_RATE) begin
            w_div_req.start = (r_ticks != '0);
        end else if (r_state == S_AVG) begin
            w_div_req.start    = 1'b1;
            w_div_req.dividend = r_prod;
            w_div_req.divisor  = r_wtime;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_RATE;
                end
            end
            S_RATE: begin
                n_state = (r_ticks != '0) ? S_RATE_WAIT : S_CHECK;
            end
            S_RATE_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = w_close ? S_AVG : S_DONE;
            end
            S_AVG: begin
                n_state = S_AVG_WAIT;
            end
            S_AVG_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wtime   <= '0;
            r_wframes <= '0;
            r_avg     <= '0;
            r_smooth  <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_wtime  <= r_wtime + {1'b0, w_ticks};
                r_smooth <= n_smooth;
                if (r_wframes != '1) begin
                    r_wframes <= r_wframes + 1'b1;
                end
            end
            // divider has latched the window sums, so the window opens afresh
            if (r_state == S_AVG) begin
                r_wtime   <= '0;
                r_wframes <= '0;
            end
            if ((r_state == S_AVG_WAIT) && w_div_rsp.done) begin
                r_avg <= w_div_rsp.quotient;
            end
        end
    end

    // per-item working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ticks <= w_ticks;
        end
        if ((r_state == S_RATE) && (r_ticks == '0)) begin
            r_rate <= '0;
        end else if ((r_state == S_RATE_WAIT) && w_div_rsp.done) begin
            r_rate <= w_div_rsp.quotient;
        end
        if (r_state == S_CHECK) begin
            r_prod <= w_prod;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_dt     <= r_ticks;
            r_out_rate   <= r_rate;
            r_out_avg    <= r_avg;
            r_out_smooth <= r_smooth;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.frame_dt     = r_out_dt;
    assign o_out.frame_rate   = r_out_rate;
    assign o_out.average_rate = r_out_avg;
    assign o_out.smoothed_dt  = r_out_smooth;

endmodule

`default_nettype wire

FILE: hdl/frm_cfg.sv
// apb register file holding tick_rate
`default_nettype none

module frm_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [frm_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [frm_pkg::DATA_W-1:0]      pwdata,
    output logic      [frm_pkg::DATA_W-1:0]      prdata,
    output logic                                 pready,
    output logic      [frm_pkg::DATA_W-1:0]      o_tick_rate
);

    logic [frm_pkg::DATA_W-1:0]       r_tick_rate;
    logic [frm_pkg::REG_IDX_W-1:0]    w_idx;
    logic                             w_wr_tick_rate;

    assign w_idx  = paddr[frm_pkg::PADDR_W-1:2];
    assign pready = 1'b1;

    always_comb begin
        w_wr_tick_rate = 1'b0;
        prdata         = '0;
        unique case (w_idx)
            frm_pkg::REG_TICK_RATE: begin
                w_wr_tick_rate = psel && penable && pwrite;
                prdata         = r_tick_rate;
            end
            default: begin
                w_wr_tick_rate = 1'b0;
                prdata         = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate <= frm_pkg::TICK_RATE_RESET;
        end else if (w_wr_tick_rate) begin
            r_tick_rate <= pwdata;
        end
    end

    assign o_tick_rate = r_tick_rate;

endmodule

`default_nettype wire

FILE: hdl/frm_div.sv
// bit-serial restoring divider, floor(dividend * 2^frac / divisor) saturated to 32 bits
`default_nettype none

module frm_div #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire frm_pkg::t_div_req  i_req,
    output frm_pkg::t_div_rsp       o_rsp
);

    localparam int NW = frm_pkg::PROD_W + FRAC_BITS;
    localparam int QW = frm_pkg::RATE_W;
    localparam int HW = NW - QW;
    localparam int CW = (HW > frm_pkg::WTIME_W) ? HW : frm_pkg::WTIME_W;
    localparam int CNT_W = $clog2(QW);

    logic [NW-1:0]                 w_num;
    logic [HW-1:0]                 w_high;
    logic                          w_sat;
    logic [frm_pkg::WTIME_W:0]     w_trial;
    logic [frm_pkg::WTIME_W:0]     w_dext;
    logic                          w_ge;
    logic [frm_pkg::WTIME_W-1:0]   n_rem;

    logic                          r_run;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [frm_pkg::WTIME_W-1:0]   r_rem;
    logic [frm_pkg::WTIME_W-1:0]   r_d;
    logic [QW-1:0]                 r_lq;

    // upper part of the scaled dividend: if it already reaches the divisor
    // the quotient needs more than 32 bits
    assign w_num  = NW'(i_req.dividend) << FRAC_BITS;
    assign w_high = w_num[NW-1:QW];
    assign w_sat  = CW'(w_high) >= CW'(i_req.divisor);

    // one quotient bit per cycle; low dividend bits shift out as quotient shifts in
    assign w_trial = {r_rem, r_lq[QW-1]};
    assign w_dext  = {1'b0, r_d};
    assign w_ge    = w_trial >= w_dext;

    always_comb begin
        if (w_ge) begin
            n_rem = frm_pkg::WTIME_W'(w_trial - w_dext);
        end else begin
            n_rem = w_trial[frm_pkg::WTIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_req.start) begin
                // a saturating quotient is done at once, otherwise the steps run
                r_done <= w_sat;
                r_run  <= !w_sat;
            end else if (r_run && (&r_cnt)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= '0;
            r_d   <= i_req.divisor;
            r_rem <= frm_pkg::WTIME_W'(w_high);
            r_lq  <= w_sat ? '1 : w_num[QW-1:0];
        end else if (r_run) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= n_rem;
            r_lq  <= {r_lq[QW-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_lq;

endmodule

`default_nettype wire

FILE: hdl/frm_checker.sv
// port-level checks of the frame rate meter, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module frm_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           i_in_ready,
    input wire logic                           i_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [frm_pkg::TICK_W-1:0]     i_out_frame_dt,
    input wire logic [frm_pkg::RATE_W-1:0]     i_out_frame_rate
);

    // stalled result stays offered
    `FRM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    // stalled frame_dt and frame_rate do not change
    `FRM_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_frame_dt) && $stable(i_out_frame_rate), "result changed while stalled")

    // one item in flight: an accepted item closes the input
    `FRM_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input open while an item is at work")

    // a zero duration gives a zero instant rate
    `FRM_ASSERT_IMPL(a_zero_dt_rate, i_clk, i_rst_n, i_out_valid && (i_out_frame_dt == '0), i_out_frame_rate == '0, "nonzero rate for zero duration")

endmodule

bind frame_rate_meter_top frm_checker u_frm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_frame_dt   (o_out.frame_dt),
    .i_out_frame_rate (o_out.frame_rate)
);

`default_nettype wire
